@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

@@ src/aes_pkg.sv @@
// Package for the AES-128 CBC block: state type, register indexes, S-boxes.
// No dependencies.
package aes_pkg;

    localparam int unsigned ADDR_W = 6;

    typedef enum logic [2:0] {
        REG_KEY_HIGH  = 3'd0,
        REG_KEY_LOW   = 3'd1,
        REG_IV_HIGH   = 3'd2,
        REG_IV_LOW    = 3'd3,
        REG_DIRECTION = 3'd4
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_OUT
    } state_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

@@ src/aes_round.sv @@
// One shared AES round: forward or inverse, with optional column mix and a key add.
// Depends on aes_pkg.
module aes_round (
    input  logic         decrypt,
    input  logic         last,
    input  logic [127:0] state_in,
    input  logic [127:0] rkey,
    output logic [127:0] state_out
);
    import aes_pkg::*;

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] k [16];
    logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state_in[127 - 8*i -: 8];
            k[i] = rkey[127 - 8*i -: 8];
        end
        // byte substitution and row shift
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (decrypt)
                begin
                    t[c*4+r] = inv_sbox(s[((c - r + 4) & 3)*4 + r]);
                end
                else
                begin
                    t[c*4+r] = sbox(s[((c + r) & 3)*4 + r]);
                end
            end
        end
        // inverse round adds the key before mixing
        if (decrypt)
        begin
            for (int i = 0; i < 16; i++)
            begin
                t[i] = t[i] ^ k[i];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
            x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
            y0 = xtime(x0 ^ x2); y1 = xtime(x1 ^ x3);
            if (decrypt)
            begin
                // fold the 4x terms in first so the forward mix yields the inverse mix
                a0 = a0 ^ y0; a2 = a2 ^ y0;
                a1 = a1 ^ y1; a3 = a3 ^ y1;
                x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
            end
            m[c*4]   = x0 ^ x1 ^ a1 ^ a2 ^ a3;
            m[c*4+1] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
            m[c*4+2] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
            m[c*4+3] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
        end
        for (int i = 0; i < 16; i++)
        begin
            if (last)
            begin
                state_out[127 - 8*i -: 8] = decrypt ? t[i] : (t[i] ^ k[i]);
            end
            else
            begin
                state_out[127 - 8*i -: 8] = decrypt ? m[i] : (m[i] ^ k[i]);
            end
        end
    end
endmodule

@@ src/aes128_cbc_cipher.sv @@
// Top level of the AES-128 CBC cipher: registers, key schedule, round sequencer.
// Depends on aes_pkg and aes_round.
//
//  port group   dir  handshake          payload
//  in           in   in_valid/in_stall  block_high, block_low, first_block
//  out          out  out_valid/out_stall result_high, result_low
//  cfg          in   APB write/read     key, iv, direction (64-bit data)
//
// A beat is taken in an idle cycle; a load state (chain XOR and first key
// add), ten passes through the shared round unit and an output state put the
// result on the ports. The next beat can be taken in the cycle after the
// output cycle, so a new beat waits until the last one is through.
// After a key write the next beat first expands the eleven round keys,
// one key per cycle, through the key schedule S-box row.
// Reset clears control, chain, keys_ready and config registers.
// The result register holds while out_stall is high; a new beat may still be
// taken, and its output cycle waits until the held result drains.
module aes128_cbc_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [aes_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic        first_block,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);
    import aes_pkg::*;

    logic [63:0]  key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic         direction_reg;
    logic [127:0] chain_reg;
    logic         keys_ready_reg;
    logic [127:0] rk_mem [11];
    logic [127:0] kexp_reg;
    logic [7:0]   rcon_reg;
    logic [3:0]   cnt_reg;
    logic [127:0] state_reg;
    logic [127:0] in_blk_reg;
    logic         first_reg;
    logic         dec_reg;
    logic         out_valid_reg;
    state_t       st_reg, st_next;

    logic         cfg_wr;
    reg_index_t   widx;
    logic [127:0] kexp_next;
    logic [127:0] round_out;
    logic [127:0] rk_rd;
    logic [127:0] chain_use;
    logic [3:0]   rk_idx;
    logic [3:0]   rd_round;
    logic         dec_now;
    logic         last_round;
    logic         out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign widx   = reg_index_t'(paddr[5:3]);

    always_comb
    begin
        unique case (reg_index_t'(paddr[5:3]))
            REG_KEY_HIGH:  prdata = key_high_reg;
            REG_KEY_LOW:   prdata = key_low_reg;
            REG_IV_HIGH:   prdata = iv_high_reg;
            REG_IV_LOW:    prdata = iv_low_reg;
            REG_DIRECTION: prdata = {63'd0, direction_reg};
            default:       prdata = 64'd0;
        endcase
    end

    // one key schedule step: word rotate, substitute, round constant
    always_comb
    begin
        logic [31:0] w0, w1, w2, w3, t;
        w0 = kexp_reg[127:96]; w1 = kexp_reg[95:64];
        w2 = kexp_reg[63:32];  w3 = kexp_reg[31:0];
        t = {sbox(w3[23:16]) ^ rcon_reg, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        kexp_next = {w0, w1, w2, w3};
    end

    // round whose key the next cycle needs; the read is registered
    always_comb
    begin
        unique case (st_reg)
            ST_LOAD:  rd_round = 4'd1;
            ST_ROUND: rd_round = last_round ? 4'd10 : 4'(cnt_reg + 4'd1);
            default:  rd_round = 4'd0;
        endcase
    end

    // round key index: forward counts up, inverse counts down
    assign dec_now    = (st_reg == ST_IDLE) ? direction_reg : dec_reg;
    assign rk_idx     = dec_now ? 4'(4'd10 - rd_round) : rd_round;
    assign last_round = (cnt_reg == 4'd10);

    always_ff @(posedge clk)
    begin
        // inverse order starts at the key being written on the last expand cycle
        if (st_reg == ST_EXPAND && dec_reg)
            rk_rd <= kexp_reg;
        else
            rk_rd <= rk_mem[rk_idx];
        if (st_reg == ST_EXPAND)
        begin
            rk_mem[cnt_reg] <= kexp_reg;
        end
    end

    aes_round u_round (
        .decrypt   (dec_reg),
        .last      (last_round),
        .state_in  (state_reg),
        .rkey      (rk_rd),
        .state_out (round_out)
    );

    assign chain_use = first_reg ? {iv_high_reg, iv_low_reg} : chain_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (st_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    st_next = keys_ready_reg ? ST_LOAD : ST_EXPAND;
                end
            end
            ST_EXPAND: if (cnt_reg == 4'd10) st_next = ST_LOAD;
            ST_LOAD:   st_next = ST_ROUND;
            ST_ROUND:  if (last_round) st_next = ST_OUT;
            ST_OUT:    if (out_free) st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_IDLE;
            key_high_reg   <= '0;
            key_low_reg    <= '0;
            iv_high_reg    <= '0;
            iv_low_reg     <= '0;
            direction_reg  <= 1'b0;
            chain_reg      <= '0;
            keys_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_wr)
            begin
                unique case (widx)
                    REG_KEY_HIGH:  key_high_reg <= pwdata;
                    REG_KEY_LOW:   key_low_reg <= pwdata;
                    REG_IV_HIGH:   iv_high_reg <= pwdata;
                    REG_IV_LOW:    iv_low_reg <= pwdata;
                    REG_DIRECTION: direction_reg <= pwdata[0];
                    default:       ;
                endcase
            end
            // a key write drops the schedule; the last expand step restores it
            if (st_reg == ST_EXPAND && cnt_reg == 4'd10)
                keys_ready_reg <= 1'b1;
            else if (cfg_wr && (widx == REG_KEY_HIGH || widx == REG_KEY_LOW))
                keys_ready_reg <= 1'b0;
            if (st_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE:   cnt_reg <= '0;
                ST_EXPAND: cnt_reg <= (cnt_reg == 4'd10) ? 4'd0 : 4'(cnt_reg + 4'd1);
                ST_LOAD:   cnt_reg <= 4'd1;
                ST_ROUND:  cnt_reg <= 4'(cnt_reg + 4'd1);
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        chain_reg <= dec_reg ? in_blk_reg : state_reg;
                    end
                end
                default:   cnt_reg <= '0;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && in_valid && !in_stall)
        begin
            in_blk_reg <= {block_high, block_low};
            first_reg  <= first_block;
            dec_reg    <= direction_reg;
            kexp_reg   <= {key_high_reg, key_low_reg};
            rcon_reg   <= 8'h01;
        end
        if (st_reg == ST_EXPAND)
        begin
            kexp_reg <= kexp_next;
            rcon_reg <= xtime(rcon_reg);
        end
        if (st_reg == ST_LOAD)
        begin
            state_reg <= rk_rd ^ (dec_reg ? in_blk_reg : (in_blk_reg ^ chain_use));
        end
        if (st_reg == ST_ROUND)
        begin
            state_reg <= round_out;
        end
        if (st_reg == ST_OUT && out_free)
        begin
            result_high <= dec_reg ? state_reg[127:64] ^ chain_use[127:64] : state_reg[127:64];
            result_low  <= dec_reg ? state_reg[63:0] ^ chain_use[63:0] : state_reg[63:0];
        end
    end
endmodule

@@ src/aes_checker.sv @@
// Port-level checks for the AES-128 CBC cipher, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module aes_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic [63:0] result_high
);
    `ASSERT_IMPL(valid_holds, clk, rst_n, (out_valid && out_stall) |=> out_valid, "result dropped under stall")
    `ASSERT_IMPL(busy_after_take, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "ready right after a beat")
    `ASSERT_IMPL(no_early_retake, clk, rst_n, (in_valid && !in_stall) |=> in_stall [*11], "ready again too soon")
    `ASSERT_IMPL(out_holds, clk, rst_n, (out_valid && out_stall) |=> $stable(result_high), "result moved under stall")
endmodule

bind aes128_cbc_cipher aes_checker u_aes_checker (.*);

@@ verif/tb_aes128_cbc_cipher.sv @@
// Self-checking testbench for the AES-128 CBC cipher: directed rows, then random phases.
// Depends on aes_pkg (register indexes, address width) and the aes128_cbc_cipher RTL.
module tb_aes128_cbc_cipher;

    import aes_pkg::*;

    localparam int         RANDOM_BEATS     = 1000;
    localparam int         WATCHDOG_LIMIT   = 5000;
    localparam int         DRAIN_CYCLES     = 16;
    localparam logic [2:0] REG_OUT_OF_RANGE = 3'd5;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] result_high;
    logic [63:0] result_low;

    aes128_cbc_cipher DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .block_high(block_high), .block_low(block_low), .first_block(first_block),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_high(result_high), .result_low(result_low)
    );

    // Free-running clock, period 10.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Cipher predictor. Tables are built from GF(2^8) arithmetic at time
    // zero so nothing is shared with the design's S-box functions.
    // Bytes of a 128-bit block sit with byte 0 in bits 127:120.
    // ------------------------------------------------------------------
    logic [7:0]   fwd_sub [256];
    logic [7:0]   rev_sub [256];
    logic [63:0]  shadow_key_hi, shadow_key_lo, shadow_iv_hi, shadow_iv_lo;
    logic         shadow_decrypt;
    logic [127:0] chain_value;
    logic [127:0] sched_keys [11];
    logic         sched_ready;

    logic [127:0] pending_blocks [$];
    int           error_count;
    int           idle_cycles;
    bit           quiet_phase;     // no gaps and no stalls while set

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[0]) p = p ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic void build_sub_tables();
        logic [7:0] inv;
        logic [7:0] s;
        for (int a = 0; a < 256; a++)
        begin
            inv = 8'h00;
            for (int b = 1; b < 256; b++)
                if (a != 0 && gmul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_sub[a] = s;
            rev_sub[s] = a[7:0];
        end
    endfunction

    function automatic logic [7:0] byte_of(input logic [127:0] x, input int i);
        return x[127-8*i -: 8];
    endfunction

    function automatic void expand_schedule();
        logic [7:0] w [176];
        logic [7:0] t [4];
        logic [7:0] x;
        logic [7:0] rc;
        logic [127:0] kk;
        rc = 8'h01;
        kk = {shadow_key_hi, shadow_key_lo};
        for (int i = 0; i < 16; i++) w[i] = byte_of(kk, i);
        for (int n = 16; n < 176; n += 4)
        begin
            for (int i = 0; i < 4; i++) t[i] = w[n-4+i];
            if ((n % 16) == 0)
            begin
                x = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = x;
                for (int i = 0; i < 4; i++) t[i] = fwd_sub[t[i]];
                t[0] = t[0] ^ rc;
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end
            for (int i = 0; i < 4; i++) w[n+i] = w[n-16+i] ^ t[i];
        end
        for (int r = 0; r < 11; r++)
            for (int i = 0; i < 16; i++) sched_keys[r][127-8*i -: 8] = w[16*r+i];
        sched_ready = 1'b1;
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s, input bit rev);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                if (rev)
                    t[127-8*(c*4+r) -: 8] = rev_sub[byte_of(s, ((c - r + 4) % 4) * 4 + r)];
                else
                    t[127-8*(c*4+r) -: 8] = fwd_sub[byte_of(s, ((c + r) % 4) * 4 + r)];
        return t;
    endfunction

    function automatic logic [127:0] col_mix(input logic [127:0] s, input bit rev);
        logic [127:0] t;
        logic [7:0]   m [4];
        if (rev) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else     m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(c*4+r) -: 8] = gmul(m[0], byte_of(s, c*4 + r))
                                      ^ gmul(m[1], byte_of(s, c*4 + (r+1)%4))
                                      ^ gmul(m[2], byte_of(s, c*4 + (r+2)%4))
                                      ^ gmul(m[3], byte_of(s, c*4 + (r+3)%4));
        return t;
    endfunction

    // One CBC step: expand keys if stale, reload chain on a first block.
    function automatic logic [127:0] cbc_step(input logic [127:0] blk, input logic fb);
        logic [127:0] s;
        if (!sched_ready) expand_schedule();
        if (fb) chain_value = {shadow_iv_hi, shadow_iv_lo};
        if (!shadow_decrypt)
        begin
            s = (blk ^ chain_value) ^ sched_keys[0];
            for (int r = 1; r < 10; r++)
                s = col_mix(sub_shift(s, 1'b0), 1'b0) ^ sched_keys[r];
            s = sub_shift(s, 1'b0) ^ sched_keys[10];
            chain_value = s;
        end
        else
        begin
            s = blk ^ sched_keys[10];
            for (int r = 9; r >= 1; r--)
                s = col_mix(sub_shift(s, 1'b1) ^ sched_keys[r], 1'b1);
            s = (sub_shift(s, 1'b1) ^ sched_keys[0]) ^ chain_value;
            chain_value = blk;
        end
        return s;
    endfunction

    function automatic void shadow_write(input logic [2:0] idx, input logic [63:0] val);
        case (idx)
            REG_KEY_HIGH:  begin shadow_key_hi = val; sched_ready = 1'b0; end
            REG_KEY_LOW:   begin shadow_key_lo = val; sched_ready = 1'b0; end
            REG_IV_HIGH:   shadow_iv_hi = val;
            REG_IV_LOW:    shadow_iv_lo = val;
            REG_DIRECTION: shadow_decrypt = val[0];
            default:       ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (quiet_phase || r < 6) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // APB write: setup cycle, then access cycle; register lands at the
    // edge where psel, penable, pwrite and pready are all high.
    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        idle_cycles = 0;
        shadow_write(idx, val);
    endtask

    // Send one input beat; hold payload until accepted, then predict it.
    task automatic send_beat(input logic [63:0] bh, input logic [63:0] bl, input logic fb,
                             input bit known, input logic [127:0] known_res);
        int gap;
        logic [127:0] predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        block_high  <= bh;
        block_low   <= bl;
        first_block <= fb;
        do @(posedge clk); while (in_stall);
        predicted = cbc_step({bh, bl}, fb);
        pending_blocks.insert(pending_blocks.size(), known ? known_res : predicted);
    endtask

    // Hold the sender until every expected result has drained.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 64'h0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stall stretches, check each accepted result beat.
    // ------------------------------------------------------------------
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        logic [127:0] want;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                idle_cycles = 0;
                if (pending_blocks.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: %h %h",
                             $realtime, result_high, result_low);
                    error_count++;
                end
                else
                begin
                    want = pending_blocks.pop_front();
                    if (result_high !== want[127:64])
                    begin
                        $display("%0t: result_high expected %h actual %h",
                                 $realtime, want[127:64], result_high);
                        error_count++;
                    end
                    if (result_low !== want[63:0])
                    begin
                        $display("%0t: result_low expected %h actual %h",
                                 $realtime, want[63:0], result_low);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                out_stall <= (stall_left > 0);
            end
        end
    end

    // Watchdog: count cycles in which nothing moves on any port.
    always @(posedge clk)
    begin
        if (in_valid && !in_stall) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $realtime);
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed rows
    // ------------------------------------------------------------------
    typedef struct {
        bit           is_cfg;
        logic [2:0]   idx;
        logic [63:0]  val;
        logic [127:0] blk;
        logic         fb;
        bit           known;
        logic [127:0] known_res;
    } stim_row_t;

    stim_row_t directed_rows [$];

    function automatic void add_cfg(input logic [2:0] idx, input logic [63:0] val);
        stim_row_t r;
        r = '{1'b1, idx, val, 128'h0, 1'b0, 1'b0, 128'h0};
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic void add_beat(input logic [127:0] blk, input logic fb,
                                     input bit known, input logic [127:0] res);
        stim_row_t r;
        r = '{1'b0, 3'd0, 64'h0, blk, fb, known, res};
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic void build_directed();
        // Zero key, zero chain after reset with no first block.
        add_beat(128'h0, 1'b0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e);
        add_cfg(REG_KEY_HIGH, 64'h0001020304050607);
        add_cfg(REG_KEY_LOW,  64'h08090a0b0c0d0e0f);
        add_beat(128'h00112233445566778899aabbccddeeff, 1'b1, 1'b1,
                 128'h69c4e0d86a7b0430d8cdb78070b4c55a);
        add_beat('1, 1'b0, 1'b0, 128'h0);
        add_beat('1, 1'b1, 1'b0, 128'h0);
        // IV written mid-message: only the next first block picks it up.
        add_cfg(REG_IV_HIGH, '1);
        add_cfg(REG_IV_LOW,  '1);
        add_beat(128'h0, 1'b0, 1'b0, 128'h0);
        add_beat(128'h0, 1'b1, 1'b0, 128'h0);
        add_cfg(REG_DIRECTION, 64'h1);
        add_beat(128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1, 1'b1,
                 128'hffeeddccbbaa99887766554433221100);
        add_cfg(REG_IV_HIGH, 64'h0);
        add_cfg(REG_IV_LOW,  64'h0);
        add_beat(128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1, 1'b1,
                 128'h00112233445566778899aabbccddeeff);
        add_beat('1, 1'b0, 1'b0, 128'h0);
        // Direction flipped mid-message: chain carries over.
        add_cfg(REG_DIRECTION, 64'h0);
        add_beat(128'h0123456789abcdeffedcba9876543210, 1'b0, 1'b0, 128'h0);
        add_cfg(REG_OUT_OF_RANGE, '1);
        add_beat(128'h0, 1'b0, 1'b0, 128'h0);
        add_cfg(REG_KEY_HIGH, '1);
        add_cfg(REG_KEY_LOW,  '1);
        add_beat('1, 1'b1, 1'b0, 128'h0);
        add_cfg(REG_DIRECTION, 64'h1);
        add_beat('1, 1'b0, 1'b0, 128'h0);
        add_beat(128'h0, 1'b1, 1'b0, 128'h0);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int sent;
        int n;
        stim_row_t row;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; block_high = '0; block_low = '0; first_block = 1'b0;
        rst_n = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        quiet_phase = 1'b0;
        shadow_key_hi = '0; shadow_key_lo = '0; shadow_iv_hi = '0; shadow_iv_lo = '0;
        shadow_decrypt = 1'b0;
        chain_value = '0;
        sched_ready = 1'b0;
        build_sub_tables();
        build_directed();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: config rows go in only with the pipe empty.
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_cfg)
            begin
                drain();
                cfg_write(row.idx, row.val);
            end
            else
                send_beat(row.blk[127:64], row.blk[63:0], row.fb, row.known, row.known_res);
        end

        // Random phases: reconfigure while idle, then a run of chained messages.
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            drain();
            quiet_phase = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1)) cfg_write(REG_KEY_HIGH, rand_word());
            if ($urandom_range(0, 1)) cfg_write(REG_KEY_LOW, rand_word());
            if ($urandom_range(0, 1)) cfg_write(REG_IV_HIGH, rand_word());
            if ($urandom_range(0, 1)) cfg_write(REG_IV_LOW, rand_word());
            if ($urandom_range(0, 1)) cfg_write(REG_DIRECTION, {$urandom, $urandom});
            if ($urandom_range(0, 7) == 0)
                cfg_write(3'($urandom_range(REG_OUT_OF_RANGE, 7)), rand_word());
            n = $urandom_range(20, 60);
            for (int k = 0; k < n; k++)
            begin
                send_beat(rand_word(), rand_word(),
                          1'((k == 0) ? $urandom_range(0, 1) : ($urandom_range(0, 9) == 0)),
                          1'b0, 128'h0);
                sent++;
            end
        end

        // Wind down: wait for the last results, then a short tail.
        in_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
